@@ hw/rtl/mvt_pkg.sv @@
package mvt_pkg;

  localparam int LANES = 4;
  localparam int MAT_ENTRIES = LANES * LANES;
  localparam int IDX_W = $clog2(MAT_ENTRIES);

  localparam int DEF_WORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS = 16;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    logic adv_sum;
    logic adv_out;
  } pipe_ctl_t;

endpackage

@@ hw/rtl/mvt_lane.sv @@
module mvt_lane import mvt_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [WORD_WIDTH-1:0]  vec_elem,
  input  logic signed [WORD_WIDTH-1:0]  column [LANES],
  output logic signed [2*WORD_WIDTH-1:0] prod [LANES]
);

  localparam int PROD_W = 2 * WORD_WIDTH;

  logic signed [PROD_W-1:0] prod_next [LANES];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      prod_next[j] = PROD_W'(vec_elem) * PROD_W'(column[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= prod_next;
    end
  end

endmodule

@@ hw/rtl/mvt_merge.sv @@
module mvt_merge import mvt_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  pipe_ctl_t                      ctl,
  input  logic signed [2*WORD_WIDTH-1:0] prod [LANES][LANES],
  output logic signed [WORD_WIDTH-1:0]   result [LANES]
);

  localparam int PROD_W = 2 * WORD_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [PAIR_W-1:0]     pair_a [LANES];
  logic signed [PAIR_W-1:0]     pair_b [LANES];
  logic signed [PAIR_W-1:0]     pair_a_next [LANES];
  logic signed [PAIR_W-1:0]     pair_b_next [LANES];
  logic signed [SUM_W-1:0]      total [LANES];
  logic signed [SUM_W-1:0]      shifted [LANES];
  logic signed [WORD_WIDTH-1:0] result_next [LANES];
  logic                         hi_ones [LANES];
  logic                         hi_zeros [LANES];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      pair_a_next[j] = PAIR_W'(prod[0][j]) + PAIR_W'(prod[1][j]);
      pair_b_next[j] = PAIR_W'(prod[2][j]) + PAIR_W'(prod[3][j]);
    end
  end

  // saturate to one word after the arithmetic shift
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      total[j]    = SUM_W'(pair_a[j]) + SUM_W'(pair_b[j]);
      shifted[j]  = total[j] >>> FRAC_BITS;
      hi_ones[j]  = &shifted[j][SUM_W-1:WORD_WIDTH-1];
      hi_zeros[j] = ~|shifted[j][SUM_W-1:WORD_WIDTH-1];
      if (hi_ones[j] || hi_zeros[j]) begin
        result_next[j] = shifted[j][WORD_WIDTH-1:0];
      end else if (shifted[j][SUM_W-1]) begin
        result_next[j] = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
        result_next[j] = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_sum) begin
      pair_a <= pair_a_next;
      pair_b <= pair_b_next;
    end
    if (ctl.adv_out) begin
      result <= result_next;
    end
  end

endmodule

@@ hw/rtl/matrix4_vector_transform_unit.sv @@
// 4x4 matrix by vector transform in signed fixed point (Q16.16 by default).
// A load transaction (op 0) writes one column-major matrix entry and gives no
// result; a transform transaction (op 1) gives out[j] = sum over k of
// v[k] * m[4k+j], shifted right arithmetically by FRAC_BITS and saturated to
// one word. One transaction is taken every cycle unless in_stall is high; a
// transform result passes through three pipeline stages (the first registers
// at the accepting edge): four lanes of multipliers, pair adders, then final
// add with shift and saturation into the output register.
// A transform sees every load accepted before it.
module matrix4_vector_transform_unit import mvt_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [IDX_W-1:0]             entry_index,
  input  logic signed [WORD_WIDTH-1:0] entry_value,
  input  logic signed [WORD_WIDTH-1:0] vec_x,
  input  logic signed [WORD_WIDTH-1:0] vec_y,
  input  logic signed [WORD_WIDTH-1:0] vec_z,
  input  logic signed [WORD_WIDTH-1:0] vec_w,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [WORD_WIDTH-1:0] out_x,
  output logic signed [WORD_WIDTH-1:0] out_y,
  output logic signed [WORD_WIDTH-1:0] out_z,
  output logic signed [WORD_WIDTH-1:0] out_w
);

  logic signed [WORD_WIDTH-1:0]   mat [MAT_ENTRIES];
  logic signed [WORD_WIDTH-1:0]   vec [LANES];
  logic signed [WORD_WIDTH-1:0]   column [LANES][LANES];
  logic signed [2*WORD_WIDTH-1:0] prod [LANES][LANES];
  logic signed [WORD_WIDTH-1:0]   result [LANES];
  logic                           v1, v2, v3;
  logic                           ready1, ready2, ready3;
  logic                           accept, load_hit;
  pipe_ctl_t                      ctl;

  assign ready3   = !v3 || !out_stall;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;
  assign load_hit = accept && (op_t'(op) == OP_LOAD);

  assign ctl.adv_sum = ready2;
  assign ctl.adv_out = ready3;

  assign vec[0] = vec_x;
  assign vec[1] = vec_y;
  assign vec[2] = vec_z;
  assign vec[3] = vec_w;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      for (int j = 0; j < LANES; j++) begin
        column[k][j] = mat[LANES * k + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAT_ENTRIES; i++) begin
        mat[i] <= '0;
      end
    end else if (load_hit) begin
      mat[entry_index] <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid && (op_t'(op) == OP_XFORM);
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mvt_lane #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_lane (
      .clk      (clk),
      .adv      (ready1),
      .vec_elem (vec[k]),
      .column   (column[k]),
      .prod     (prod[k])
    );
  end

  mvt_merge #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk    (clk),
    .ctl    (ctl),
    .prod   (prod),
    .result (result)
  );

  assign out_valid = v3;
  assign out_x     = result[0];
  assign out_y     = result[1];
  assign out_z     = result[2];
  assign out_w     = result[3];

  a_stage1_kept: assert property (@(posedge clk) disable iff (rst)
    v1 |=> (v1 || v2))
    else $error("multiply stage transaction lost");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    load_hit |=> !v1)
    else $error("load transaction entered the pipeline");

  a_load_written: assert property (@(posedge clk) disable iff (rst)
    load_hit |=> (mat[$past(entry_index)] == $past(entry_value)))
    else $error("matrix entry not written");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule
